[rtl/core/itfr_pkg.sv]
// Shared types, status codes and helpers for the ISO-TP receive reassembly block.
// No dependencies; used by isotp_frame_reassembly.
package itfr_pkg;

    // result status codes
    localparam logic [3:0] STAT_SINGLE  = 4'd0;
    localparam logic [3:0] STAT_FIRST   = 4'd1;
    localparam logic [3:0] STAT_CONSEC  = 4'd2;
    localparam logic [3:0] STAT_DONE    = 4'd3;
    localparam logic [3:0] STAT_SEQERR  = 4'd4;
    localparam logic [3:0] STAT_NOCTX   = 4'd5;
    localparam logic [3:0] STAT_IGNORED = 4'd6;
    localparam logic [3:0] STAT_FULL    = 4'd7;
    localparam logic [3:0] STAT_EXPIRED = 4'd8;

    // PCI frame types (upper nibble of byte 0)
    localparam logic [3:0] PCI_SINGLE = 4'd0;
    localparam logic [3:0] PCI_FIRST  = 4'd1;
    localparam logic [3:0] PCI_CONSEC = 4'd2;

    localparam logic [3:0]  DLC_MAX        = 4'd8;
    localparam logic [3:0]  MAX_RESULTS    = 4'd8;
    localparam logic [15:0] AGE_MAX        = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    // one reassembly context as stored in the slot RAM
    typedef struct packed {
        logic [15:0] age;
        logic [3:0]  next_seq;
        logic [12:0] received;
        logic [11:0] total;
        logic [28:0] id;
    } slot_t;

    // one result item, packed so the tdata fields sit lowest-first
    typedef struct packed {
        logic        last;
        logic [3:0]  status;
        logic [55:0] payload;
        logic [11:0] total;
        logic [2:0]  count;
        logic [12:0] offset;
        logic [28:0] msg_id;
    } res_t;

    // keep the lowest n bytes of a 7-byte payload, zero the rest
    function automatic logic [55:0] keep_bytes(input logic [55:0] v, input logic [2:0] n);
        logic [55:0] m;
        m = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return v & m;
    endfunction

endpackage

[rtl/core/isotp_frame_reassembly.sv]
// Top level of the ISO-TP receive reassembly block: control FSM, slot valid bits, result path.
// Depends on itfr_pkg (types, codes, byte masking) and itfr_ram (slot table).

// ISO-TP receive reassembly. Each request on the s_ side is either a received CAN
// frame (s_tuser = 0) or one timer tick (s_tuser = 1). Frames are decoded by PCI type:
// single frames come back at once; first frames open or restart a context keyed by
// CAN id; consecutive frames append payload in sequence order and close the context
// with a "complete" result when the announced length is reached. Ticks age every open
// context and expire those idle for timeout_ticks ticks (at most 8 per tick, lowest
// slot first). Every request except a tick with no expiry yields one or more results;
// m_tlast marks the final one. Contexts live in a one-port-read RAM of CONTEXTS
// entries, searched one slot at a time; the search stops at the matching slot.
// Output backpressure stalls a request. The search is bound by the single RAM read port.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// Configuration (timeout_ticks) is always ready and is meant to be written while idle.
module isotp_frame_reassembly #(
    parameter int CONTEXTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,

    // config write: timeout_ticks
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,

    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // can_id[28:0], dlc[32:29], data[96:33], zero[103:97]
    input  logic         s_tuser,   // cmd: 0 frame, 1 tick

    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // msg_id[28:0], offset[41:29], count[44:42],
                                    // total[56:45], payload[112:57], zero[119:113]
    output logic [3:0]   m_tuser,   // status
    output logic         m_tlast
);

    localparam int IDX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CONTEXTS - 1);
    localparam int SLOT_W = $bits(itfr_pkg::slot_t);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_SRCH_RD = 9'b000000100,
        S_SRCH_EV = 9'b000001000,
        S_ACT     = 9'b000010000,
        S_DONE    = 9'b000100000,
        S_TICK_RD = 9'b001000000,
        S_TICK_EV = 9'b010000000,
        S_FLUSH   = 9'b100000000
    } state_t;

    // ---------------------------------------------------------------- registers
    state_t               state_reg, state_next;
    logic [15:0]          timeout_reg, timeout_next;
    logic [CONTEXTS-1:0]  slot_valid_reg, slot_valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic                 free_seen_reg, free_seen_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [3:0]           exp_cnt_reg, exp_cnt_next;
    itfr_pkg::slot_t      slot_reg, slot_next;

    logic [28:0]          item_id_reg, item_id_next;
    logic [3:0]           item_dlc_reg, item_dlc_next;
    logic [63:0]          item_data_reg, item_data_next;

    // result path: hold stage (last unknown yet) then output register
    logic                 hold_valid_reg, hold_valid_next;
    itfr_pkg::res_t       hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;
    itfr_pkg::res_t       out_reg, out_next;

    // ---------------------------------------------------------------- RAM
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    itfr_pkg::slot_t      ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata_raw;
    itfr_pkg::slot_t      ram_rdata;

    itfr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CONTEXTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = itfr_pkg::slot_t'(ram_rdata_raw);

    // ---------------------------------------------------------------- decode
    logic [3:0]  dlc_c;
    logic [3:0]  pci_type;
    logic [3:0]  pci_nib;
    logic [11:0] ff_total;
    logic [3:0]  ff_raw;
    logic [2:0]  ff_cnt;
    logic [3:0]  cf_raw;
    logic [12:0] cf_rem;
    logic [2:0]  cf_cnt;
    logic [12:0] cf_rcv;
    logic [15:0] age_inc;
    logic [15:0] limit;
    logic        expire;

    always_comb begin
        dlc_c    = (item_dlc_reg > itfr_pkg::DLC_MAX) ? itfr_pkg::DLC_MAX : item_dlc_reg;
        pci_type = item_data_reg[7:4];
        pci_nib  = item_data_reg[3:0];
        ff_total = {pci_nib, item_data_reg[15:8]};
        ff_raw   = dlc_c - 4'd2;
        ff_cnt   = ({8'd0, ff_raw} > ff_total) ? ff_total[2:0] : ff_raw[2:0];
        cf_raw   = dlc_c - 4'd1;
        cf_rem   = {1'b0, slot_reg.total} - slot_reg.received;
        cf_cnt   = ({9'd0, cf_raw} > cf_rem) ? cf_rem[2:0] : cf_raw[2:0];
        cf_rcv   = slot_reg.received + {10'd0, cf_cnt};
        age_inc  = (ram_rdata.age == itfr_pkg::AGE_MAX) ? ram_rdata.age
                                                        : ram_rdata.age + 16'd1;
        limit    = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
        expire   = (age_inc >= limit) && (exp_cnt_reg < itfr_pkg::MAX_RESULTS);
    end

    // ---------------------------------------------------------------- control
    logic            out_free;
    logic            can_push;
    logic            push;
    itfr_pkg::res_t  push_res;
    logic            flush_move;
    logic [IDX_W-1:0] tgt_idx;

    assign out_free  = !out_valid_reg || m_tready;
    assign can_push  = !hold_valid_reg || out_free;
    assign tgt_idx   = found_reg ? idx_reg : free_idx_reg;

    always_comb begin
        state_next      = state_reg;
        timeout_next    = timeout_reg;
        slot_valid_next = slot_valid_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_seen_next  = free_seen_reg;
        free_idx_next   = free_idx_reg;
        exp_cnt_next    = exp_cnt_reg;
        slot_next       = slot_reg;
        item_id_next    = item_id_reg;
        item_dlc_next   = item_dlc_reg;
        item_data_next  = item_data_reg;

        push       = 1'b0;
        push_res   = '0;
        flush_move = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = ram_rdata;

        push_res.msg_id = item_id_reg;

        if (cfg_valid) begin
            timeout_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    item_id_next   = s_tdata[28:0];
                    item_dlc_next  = s_tdata[32:29];
                    item_data_next = s_tdata[96:33];
                    idx_next       = '0;
                    found_next     = 1'b0;
                    free_seen_next = 1'b0;
                    exp_cnt_next   = '0;
                    state_next     = s_tuser ? S_TICK_RD : S_DECODE;
                end
            end

            S_DECODE: begin
                // first and consecutive frames need the table; the rest answer at once
                if (dlc_c != 4'd0 && pci_type == itfr_pkg::PCI_FIRST && dlc_c >= 4'd2) begin
                    state_next = S_SRCH_RD;
                end else if (dlc_c != 4'd0 && pci_type == itfr_pkg::PCI_CONSEC) begin
                    state_next = S_SRCH_RD;
                end else if (can_push) begin
                    push   = 1'b1;
                    if (dlc_c != 4'd0 && pci_type == itfr_pkg::PCI_SINGLE &&
                        {1'b0, dlc_c} >= {1'b0, pci_nib} + 5'd1) begin
                        push_res.status  = itfr_pkg::STAT_SINGLE;
                        push_res.count   = pci_nib[2:0];
                        push_res.total   = {8'd0, pci_nib};
                        push_res.payload = itfr_pkg::keep_bytes(item_data_reg[63:8],
                                                                pci_nib[2:0]);
                    end else begin
                        push_res.status  = itfr_pkg::STAT_IGNORED;
                    end
                    state_next = S_FLUSH;
                end
            end

            S_SRCH_RD: begin
                state_next = S_SRCH_EV;
            end

            S_SRCH_EV: begin
                if (slot_valid_reg[idx_reg] && ram_rdata.id == item_id_reg) begin
                    found_next = 1'b1;
                    slot_next  = ram_rdata;
                    state_next = S_ACT;
                end else begin
                    if (!slot_valid_reg[idx_reg] && !free_seen_reg) begin
                        free_seen_next = 1'b1;
                        free_idx_next  = idx_reg;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_ACT;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_SRCH_RD;
                    end
                end
            end

            S_ACT: begin
                if (can_push) begin
                    push = 1'b1;
                    state_next = S_FLUSH;
                    if (pci_type == itfr_pkg::PCI_FIRST) begin
                        if (!found_reg && !free_seen_reg) begin
                            push_res.status = itfr_pkg::STAT_FULL;
                            push_res.total  = ff_total;
                        end else begin
                            ram_we             = 1'b1;
                            ram_waddr          = tgt_idx;
                            ram_wdata.id       = item_id_reg;
                            ram_wdata.total    = ff_total;
                            ram_wdata.received = {10'd0, ff_cnt};
                            ram_wdata.next_seq = '0;
                            ram_wdata.age      = '0;
                            slot_valid_next[tgt_idx] = 1'b1;
                            push_res.status  = itfr_pkg::STAT_FIRST;
                            push_res.count   = ff_cnt;
                            push_res.total   = ff_total;
                            push_res.payload = itfr_pkg::keep_bytes(
                                {8'd0, item_data_reg[63:16]}, ff_cnt);
                        end
                    end else if (!found_reg) begin
                        push_res.status = itfr_pkg::STAT_NOCTX;
                    end else if (pci_nib != slot_reg.next_seq) begin
                        // out of order: drop the context
                        slot_valid_next[idx_reg] = 1'b0;
                        push_res.status = itfr_pkg::STAT_SEQERR;
                        push_res.offset = slot_reg.received;
                        push_res.total  = slot_reg.total;
                    end else begin
                        ram_we             = 1'b1;
                        ram_wdata          = slot_reg;
                        ram_wdata.received = cf_rcv;
                        ram_wdata.next_seq = slot_reg.next_seq + 4'd1;
                        ram_wdata.age      = '0;
                        push_res.status  = itfr_pkg::STAT_CONSEC;
                        push_res.offset  = slot_reg.received;
                        push_res.count   = cf_cnt;
                        push_res.total   = slot_reg.total;
                        push_res.payload = itfr_pkg::keep_bytes(item_data_reg[63:8], cf_cnt);
                        if (cf_rcv >= {1'b0, slot_reg.total}) begin
                            slot_valid_next[idx_reg] = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE: begin
                if (can_push) begin
                    push            = 1'b1;
                    push_res.status = itfr_pkg::STAT_DONE;
                    push_res.total  = slot_reg.total;
                    state_next      = S_FLUSH;
                end
            end

            S_TICK_RD: begin
                if (slot_valid_reg[idx_reg]) begin
                    state_next = S_TICK_EV;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = S_FLUSH;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_TICK_EV: begin
                if (!expire || can_push) begin
                    ram_we        = 1'b1;
                    ram_wdata.age = age_inc;
                    if (expire) begin
                        push                     = 1'b1;
                        push_res.status          = itfr_pkg::STAT_EXPIRED;
                        push_res.msg_id          = ram_rdata.id;
                        push_res.offset          = ram_rdata.received;
                        push_res.total           = ram_rdata.total;
                        slot_valid_next[idx_reg] = 1'b0;
                        exp_cnt_next             = exp_cnt_reg + 4'd1;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_TICK_RD;
                    end
                end
            end

            S_FLUSH: begin
                // the held result is the final one for this request
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    flush_move = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result path
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        if (push) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_next.last  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = push_res;
        end else if (flush_move) begin
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            timeout_reg    <= itfr_pkg::TIMEOUT_RESET;
            slot_valid_reg <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_seen_reg  <= 1'b0;
            exp_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_seen_reg  <= free_seen_next;
            exp_cnt_reg    <= exp_cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        free_idx_reg  <= free_idx_next;
        slot_reg      <= slot_next;
        item_id_reg   <= item_id_next;
        item_dlc_reg  <= item_dlc_next;
        item_data_reg <= item_data_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
    end

    // ---------------------------------------------------------------- ports
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_reg.payload, out_reg.total, out_reg.count,
                        out_reg.offset, out_reg.msg_id};
    assign m_tuser   = out_reg.status;
    assign m_tlast   = out_reg.last;

    // ---------------------------------------------------------------- checks
    // a new request is only taken once every result of the previous one left hold
    a_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !hold_valid_reg)
        else $error("request accepted with a result still held");

    // expiries per tick stay within the result limit
    a_exp_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_cnt_reg <= itfr_pkg::MAX_RESULTS)
        else $error("too many expiries in one tick");

    // table is only written while updating a context
    a_ram_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_ACT || state_reg == S_TICK_EV))
        else $error("slot RAM written outside update states");

    // a completed context is already closed when its completion result goes out
    a_done_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> !slot_valid_reg[idx_reg])
        else $error("completed context still open");

endmodule

[rtl/core/itfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the reassembly slot table.
module itfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for isotp_frame_reassembly: random and directed CAN frames and ticks.
// Depends on itfr_pkg (status codes, PCI types, result layout) and the RTL under rtl/core.
// A small in-bench slot table predicts every result; a scoreboard class checks them in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;              // CONTEXTS of the instance
    localparam logic CMD_FRAME = 1'b0;     // s_tuser: received CAN frame
    localparam logic CMD_TICK = 1'b1;      // s_tuser: one timer tick
    localparam logic [3:0] PCI_FLOW = 4'd3;       // flow control, ignored by the block
    localparam logic [3:0] PCI_UNKNOWN = 4'd15;   // reserved type, ignored as well
    localparam int SETTLE_CYCLES = 48;     // > worst request cost, with margin
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 68;

    typedef enum int {RX_STREAM, RX_CHOPPY, RX_HOLD} rx_mode_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the slot table and keeps the results still owed.
    // ------------------------------------------------------------------
    class reassembly_tracker;
        logic [15:0] timeout_ticks;
        bit          ctx_open[SLOTS];
        logic [28:0] ctx_id[SLOTS];
        logic [11:0] ctx_total[SLOTS];
        logic [12:0] ctx_got[SLOTS];
        logic [3:0]  ctx_seq[SLOTS];
        logic [15:0] ctx_age[SLOTS];
        itfr_pkg::res_t batch[$];             // results of the request being worked out
        itfr_pkg::res_t expected_results[$];  // results owed by the block, oldest first
        int          error_count;

        function new();
            timeout_ticks = itfr_pkg::TIMEOUT_RESET;
            foreach (ctx_open[i]) ctx_open[i] = 1'b0;
            error_count = 0;
        endfunction

        function int lookup(logic [28:0] id);
            foreach (ctx_open[i]) begin
                if (ctx_open[i] && ctx_id[i] == id) return i;
            end
            return -1;
        endfunction

        function int seq_of(logic [28:0] id);
            int s;
            s = lookup(id);
            return (s < 0) ? -1 : int'(ctx_seq[s]);
        endfunction

        // n frame bytes starting at byte 'first'; n is at most 7 here
        function logic [55:0] pick_bytes(logic [63:0] data, int first, int n);
            logic [63:0] v;
            v = data >> (8 * first);
            if (n < 8) v &= (64'd1 << (8 * n)) - 64'd1;
            return v[55:0];
        endfunction

        function void emit(logic [3:0] status, logic [28:0] id, int offset, int count,
                           int total, logic [55:0] payload);
            itfr_pkg::res_t r;
            r.last = 1'b0;
            r.status = status;
            r.msg_id = id;
            r.offset = 13'(offset);
            r.count = 3'(count);
            r.total = 12'(total);
            r.payload = payload;
            batch.insert(batch.size(), r);
        endfunction

        function void note_request(logic cmd, logic [28:0] id, logic [3:0] dlc,
                                   logic [63:0] data);
            int d, len, tot, cnt, prev_got, s, limit, n, i;
            logic [7:0] pci;
            batch.delete();
            if (cmd == CMD_TICK) begin
                // age every open context; expire lowest slots first, bounded per tick
                limit = (timeout_ticks == 16'd0) ? 1 : int'(timeout_ticks);
                n = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (ctx_open[i]) begin
                        if (ctx_age[i] != itfr_pkg::AGE_MAX) ctx_age[i] = ctx_age[i] + 16'd1;
                        if (int'(ctx_age[i]) >= limit && n < int'(itfr_pkg::MAX_RESULTS)) begin
                            emit(itfr_pkg::STAT_EXPIRED, ctx_id[i], int'(ctx_got[i]), 0,
                                 int'(ctx_total[i]), '0);
                            ctx_open[i] = 1'b0;
                            n++;
                        end
                    end
                end
            end else begin
                d = (dlc > itfr_pkg::DLC_MAX) ? int'(itfr_pkg::DLC_MAX) : int'(dlc);
                pci = data[7:0];
                if (d == 0) begin
                    emit(itfr_pkg::STAT_IGNORED, id, 0, 0, 0, '0);
                end else begin
                    case (pci[7:4])
                        itfr_pkg::PCI_SINGLE: begin
                            len = int'(pci[3:0]);
                            if (d < 1 + len) begin
                                emit(itfr_pkg::STAT_IGNORED, id, 0, 0, 0, '0);
                            end else begin
                                emit(itfr_pkg::STAT_SINGLE, id, 0, len, len,
                                     pick_bytes(data, 1, len));
                            end
                        end
                        itfr_pkg::PCI_FIRST: begin
                            if (d < 2) begin
                                emit(itfr_pkg::STAT_IGNORED, id, 0, 0, 0, '0);
                            end else begin
                                tot = int'({pci[3:0], data[15:8]});
                                s = lookup(id);
                                if (s < 0) begin
                                    for (i = SLOTS - 1; i >= 0; i--) begin
                                        if (!ctx_open[i]) s = i;
                                    end
                                end
                                if (s < 0) begin
                                    emit(itfr_pkg::STAT_FULL, id, 0, 0, tot, '0);
                                end else begin
                                    cnt = (d - 2 > tot) ? tot : d - 2;
                                    ctx_open[s] = 1'b1;
                                    ctx_id[s] = id;
                                    ctx_total[s] = 12'(tot);
                                    ctx_got[s] = 13'(cnt);
                                    ctx_seq[s] = 4'd0;
                                    ctx_age[s] = 16'd0;
                                    emit(itfr_pkg::STAT_FIRST, id, 0, cnt, tot,
                                         pick_bytes(data, 2, cnt));
                                end
                            end
                        end
                        itfr_pkg::PCI_CONSEC: begin
                            s = lookup(id);
                            if (s < 0) begin
                                emit(itfr_pkg::STAT_NOCTX, id, 0, 0, 0, '0);
                            end else if (pci[3:0] != ctx_seq[s]) begin
                                // out of order: context dropped
                                emit(itfr_pkg::STAT_SEQERR, id, int'(ctx_got[s]), 0,
                                     int'(ctx_total[s]), '0);
                                ctx_open[s] = 1'b0;
                            end else begin
                                prev_got = int'(ctx_got[s]);
                                cnt = d - 1;
                                if (cnt > int'(ctx_total[s]) - prev_got) begin
                                    cnt = int'(ctx_total[s]) - prev_got;
                                end
                                ctx_got[s] = 13'(prev_got + cnt);
                                ctx_seq[s] = ctx_seq[s] + 4'd1;
                                ctx_age[s] = 16'd0;
                                emit(itfr_pkg::STAT_CONSEC, id, prev_got, cnt,
                                     int'(ctx_total[s]), pick_bytes(data, 1, cnt));
                                if (ctx_got[s] >= ctx_total[s]) begin
                                    emit(itfr_pkg::STAT_DONE, id, 0, 0, int'(ctx_total[s]), '0);
                                    ctx_open[s] = 1'b0;
                                end
                            end
                        end
                        default: emit(itfr_pkg::STAT_IGNORED, id, 0, 0, 0, '0);
                    endcase
                end
            end
            if (batch.size() > 0) begin
                batch[batch.size() - 1].last = 1'b1;
                foreach (batch[k]) expected_results.insert(expected_results.size(), batch[k]);
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(itfr_pkg::res_t got);
            itfr_pkg::res_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d id %h offset %0d", $time,
                         got.status, got.msg_id, got.offset);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare("status", 64'(want.status), 64'(got.status));
            compare("msg_id", 64'(want.msg_id), 64'(got.msg_id));
            compare("offset", 64'(want.offset), 64'(got.offset));
            compare("count", 64'(want.count), 64'(got.count));
            compare("total", 64'(want.total), 64'(got.total));
            compare("payload", 64'(want.payload), 64'(got.payload));
            compare("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // can_id[28:0], dlc[32:29], data[96:33], zero[103:97]
    logic         s_tuser;   // cmd: 0 frame, 1 tick
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;   // msg_id[28:0], offset[41:29], count[44:42],
                             // total[56:45], payload[112:57], zero[119:113]
    logic [3:0]   m_tuser;   // status
    logic         m_tlast;

    reassembly_tracker tracker;
    int       burst_left = 0;
    int       stall_left = 0;
    rx_mode_t stall_mode = RX_STREAM;
    int       cycle_count;

    isotp_frame_reassembly #(
        .CONTEXTS(SLOTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver: free-flowing, choppy or fully held, each for a random stretch.
    // Holds stay short so the limit math below stays simple.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 2));
            stall_left = (stall_mode == RX_HOLD) ? $urandom_range(1, 10) : $urandom_range(4, 40);
        end
        stall_left--;
        case (stall_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
            default:   m_tready <= 1'b0;
        endcase
    end

    // Handshake monitor. Everything is sampled at the rising edge; inputs only move on
    // the falling edge. A request is noted before a result is checked in the same cycle,
    // which is harmless since a request never yields a result in its own cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.timeout_ticks = cfg_data;
            if (s_tvalid && s_tready) begin
                tracker.note_request(s_tuser, s_tdata[28:0], s_tdata[32:29], s_tdata[96:33]);
            end
            if (m_tvalid && m_tready) begin
                tracker.check_result(itfr_pkg::res_t'({m_tlast, m_tuser, m_tdata[112:0]}));
            end
        end
    end

    // byte 0 = PCI (type nibble, low nibble), bytes 1..7 = rest
    function automatic logic [63:0] pack_frame(logic [3:0] kind, logic [3:0] low,
                                               logic [55:0] rest);
        return {rest, kind, low};
    endfunction

    // One request on the s_ side. Called at a falling edge, returns at a falling edge.
    // Requests go out in bursts; between bursts tvalid drops low.
    task automatic send_request(logic cmd, logic [28:0] id, logic [3:0] dlc, logic [63:0] data);
        s_tuser <= cmd;
        s_tdata <= {7'd0, data, dlc, id};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(10, 30);
        end
    endtask

    // Idle the input, wait for every owed result, then let a silent tick finish too.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Watchdog. Worst case per request is the search, the gap between bursts and
    // 8 results each waiting out a receiver hold, for ~300 requests, plus settle
    // time per phase. The limit is several times that total.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL isotp_frame_reassembly");
        $finish;
    end

    initial begin
        logic [28:0] id_pool[10];
        logic [15:0] phase_timeout[4];
        logic [28:0] id;
        logic [63:0] data;
        logic [11:0] tot;
        logic [3:0]  dlc;
        int          kind, seq, len;

        tracker = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_FRAME;
        id_pool[0] = 29'd0;
        id_pool[1] = 29'h1FFF_FFFF;
        for (int i = 2; i < 10; i++) id_pool[i] = 29'($urandom);
        phase_timeout = '{16'hFFFF, 16'd20, 16'd3, 16'd2};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed: frame decoding at the reset timeout ----
        send_request(CMD_FRAME, 29'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);       // empty frame
        send_request(CMD_FRAME, 29'h1FFF_FFFF, 4'd1,
                     pack_frame(itfr_pkg::PCI_SINGLE, 4'd0, '0));
        send_request(CMD_FRAME, 29'd0, 4'd8, pack_frame(itfr_pkg::PCI_SINGLE, 4'd7, '1));
        // single frame longer than dlc allows
        send_request(CMD_FRAME, 29'd0, 4'd7,
                     pack_frame(itfr_pkg::PCI_SINGLE, 4'd7, 56'h11223344556677));
        // dlc above 8 counts as 8
        send_request(CMD_FRAME, 29'h0ABC_DEF1, 4'd15,
                     pack_frame(itfr_pkg::PCI_SINGLE, 4'd3, 56'h88776655443322));
        send_request(CMD_FRAME, 29'd0, 4'd8, pack_frame(itfr_pkg::PCI_SINGLE, 4'd15, '1));
        send_request(CMD_FRAME, 29'd0, 4'd1,
                     pack_frame(itfr_pkg::PCI_FIRST, 4'd15, '1));  // too short
        // zero-length message: opens, then the first CF closes it with nothing to add
        send_request(CMD_FRAME, 29'd5, 4'd8,
                     pack_frame(itfr_pkg::PCI_FIRST, 4'd0, 56'hA1A2A3A4A5A600));
        send_request(CMD_FRAME, 29'd5, 4'd8,
                     pack_frame(itfr_pkg::PCI_CONSEC, 4'd0, 56'h01020304050607));
        send_request(CMD_FRAME, 29'd5, 4'd8,
                     pack_frame(itfr_pkg::PCI_CONSEC, 4'd0, '1));   // no context
        // longest message, one CF in order, then a sequence error
        send_request(CMD_FRAME, 29'h1FFF_FFFF, 4'd8,
                     pack_frame(itfr_pkg::PCI_FIRST, 4'd15, '1));
        send_request(CMD_FRAME, 29'h1FFF_FFFF, 4'd8,
                     pack_frame(itfr_pkg::PCI_CONSEC, 4'd0, '1));
        send_request(CMD_FRAME, 29'h1FFF_FFFF, 4'd8,
                     pack_frame(itfr_pkg::PCI_CONSEC, 4'd5, '1));
        send_request(CMD_FRAME, 29'd3, 4'd3, pack_frame(PCI_FLOW, 4'd0, 56'h0A00));
        send_request(CMD_FRAME, 29'd3, 4'd8, pack_frame(PCI_UNKNOWN, 4'd0, '1));
        // restart of an open context, then a CF clipped at the announced length
        send_request(CMD_FRAME, 29'd7, 4'd8,
                     pack_frame(itfr_pkg::PCI_FIRST, 4'd0, 56'h3132333435_3608));
        send_request(CMD_FRAME, 29'd7, 4'd4,
                     pack_frame(itfr_pkg::PCI_FIRST, 4'd0, 56'h4142434445_4608));
        send_request(CMD_FRAME, 29'd7, 4'd8,
                     pack_frame(itfr_pkg::PCI_CONSEC, 4'd0, 56'h51525354555657));
        settle();

        // ---- directed: full table and mass expiry at the shortest timeout ----
        write_timeout(16'd1);
        for (int k = 0; k < SLOTS; k++) begin
            send_request(CMD_FRAME, 29'(32'h100 + k), 4'd8,
                         pack_frame(itfr_pkg::PCI_FIRST, 4'd0,
                                    {16'd0, 32'($urandom), 8'd50}));
        end
        send_request(CMD_FRAME, 29'h200, 4'd8, pack_frame(itfr_pkg::PCI_FIRST, 4'd0, 56'd50));
        send_request(CMD_TICK, 29'd0, 4'd0, '0);     // all eight expire at once
        send_request(CMD_TICK, 29'h1FFF_FFFF, 4'd15, '1);   // nothing open: silent
        settle();

        // a zero timeout acts like one tick
        write_timeout(16'd0);
        send_request(CMD_FRAME, 29'd9, 4'd8, pack_frame(itfr_pkg::PCI_FIRST, 4'd0, 56'd20));
        send_request(CMD_TICK, 29'd0, 4'd0, '0);

        // ---- random phases: mostly in-order message streams over a small id pool ----
        foreach (phase_timeout[p]) begin
            settle();
            write_timeout(phase_timeout[p]);
            repeat (RANDOM_PER_PHASE) begin
                id = id_pool[$urandom_range(0, 9)];
                data = {$urandom, $urandom};
                kind = $urandom_range(0, 99);
                seq = tracker.seq_of(id);
                if (kind < 40 && seq < 0) kind = 40;    // nothing open for this id yet
                if (kind < 40) begin
                    // next CF in order
                    dlc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(2, 15)) : 4'd8;
                    send_request(CMD_FRAME, id, dlc,
                                 pack_frame(itfr_pkg::PCI_CONSEC, 4'(seq), data[63:8]));
                end else if (kind < 58) begin
                    case ($urandom_range(0, 19))
                        0:          tot = 12'($urandom_range(0, 4095));
                        1, 2, 3, 4: tot = 12'($urandom_range(31, 120));
                        default:    tot = 12'($urandom_range(0, 30));
                    endcase
                    dlc = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd8;
                    send_request(CMD_FRAME, id, dlc,
                                 pack_frame(itfr_pkg::PCI_FIRST, tot[11:8],
                                            {data[63:16], tot[7:0]}));
                end else if (kind < 68) begin
                    len = $urandom_range(0, 7);
                    dlc = ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                      : 4'($urandom_range(len + 1, 15));
                    send_request(CMD_FRAME, id, dlc,
                                 pack_frame(itfr_pkg::PCI_SINGLE, 4'(len), data[63:8]));
                end else if (kind < 80) begin
                    send_request(CMD_TICK, 29'($urandom), 4'($urandom), data);
                end else if (kind < 88) begin
                    // CF with an arbitrary sequence number, usually out of order
                    send_request(CMD_FRAME, id, 4'd8,
                                 pack_frame(itfr_pkg::PCI_CONSEC, 4'($urandom), data[63:8]));
                end else begin
                    send_request(1'($urandom), 29'($urandom), 4'($urandom), data);
                end
            end
        end

        settle();
        if (tracker.error_count == 0) begin
            $display("PASS isotp_frame_reassembly");
        end else begin
            $display("FAIL isotp_frame_reassembly");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/itfr_pkg.sv
rtl/core/itfr_ram.sv
rtl/core/isotp_frame_reassembly.sv
dv/tb_top.sv
